@@ hw/rtl/lightmap_bilinear_style_sampler_defines.svh @@
// ---------------------------------------------------------------------------
// lightmap sampler assertion macros
// concurrent check wrappers, compiled out when ASSERT_OFF is set
// ---------------------------------------------------------------------------
`ifndef LIGHTMAP_BILINEAR_STYLE_SAMPLER_DEFINES_SVH
`define LIGHTMAP_BILINEAR_STYLE_SAMPLER_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

@@ hw/rtl/lbss_pkg.sv @@
// ---------------------------------------------------------------------------
// lightmap sampler package
// beat types, command and status structs, shared constants
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package lbss_pkg;

   localparam int SumWidth  = 18;
   localparam int OutWidth  = 20;
   localparam int GainWidth = 16;

   localparam logic [SumWidth-1:0]  SUM_MAX    = '1;
   localparam logic [OutWidth-1:0]  OUT_MAX    = '1;
   localparam logic [GainWidth-1:0] GAIN_RESET = 16'd256;

   localparam logic [1:0] CH_RED   = 2'd0;
   localparam logic [1:0] CH_GREEN = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   typedef struct packed {
      logic        last_style;
      logic [3:0]  frac_t;
      logic [3:0]  frac_s;
      logic [15:0] style_scale_blue;
      logic [15:0] style_scale_green;
      logic [15:0] style_scale_red;
      logic [23:0] texel_bottom_right;
      logic [23:0] texel_bottom_left;
      logic [23:0] texel_top_right;
      logic [23:0] texel_top_left;
   } req_type;

   typedef struct packed {
      logic [OutWidth-1:0] light_blue;
      logic [OutWidth-1:0] light_green;
      logic [OutWidth-1:0] light_red;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE    = 6'b000001,
      S_ACCUM   = 6'b000010,
      S_ROW     = 6'b000100,
      S_COL     = 6'b001000,
      S_GAIN    = 6'b010000,
      S_PUBLISH = 6'b100000
   } state_type;

   typedef struct packed {
      logic       load;
      logic       accum;
      logic       lerp_row;
      logic       lerp_col;
      logic       gain_step;
      logic       publish;
      logic [1:0] chan;
   } cmd_type;

   typedef struct packed {
      logic last_style;
      logic rsp_busy;
   } status_type;

endpackage

@@ hw/rtl/lightmap_bilinear_style_sampler.sv @@
// ---------------------------------------------------------------------------
// lightmap bilinear style sampler
// sums scaled corner texels over light styles, then lerps and applies gain
// ---------------------------------------------------------------------------
// A style map that is not marked last is taken in the idle state and then
// accumulated, one colour channel per cycle across four corner product
// lanes. A map marked last then goes, before the next beat is accepted,
// through row lerp, column lerp and gain multiply (one shared unit) for each
// channel in turn, then through a load of the result register; that load
// waits while an earlier result is still untaken. The result register lets
// a new beat in while a result is pending. Maps beyond MAX_STYLES for one
// sample point add nothing. The gain register always takes a write.
`timescale 1ns / 1ps
`include "lightmap_bilinear_style_sampler_defines.svh"

module lightmap_bilinear_style_sampler #(
   parameter int MAX_STYLES = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  lbss_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output lbss_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [15:0]       csr_data
);

   lbss_pkg::cmd_type    cmd;
   lbss_pkg::status_type status;
   logic [4:0]           strobes;

   assign csr_ready = 1'b1;

   lbss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   lbss_datapath #(
      .MAX_STYLES (MAX_STYLES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_valid (csr_valid),
      .csr_data  (csr_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   assign strobes = {cmd.accum, cmd.lerp_row, cmd.lerp_col, cmd.gain_step, cmd.publish};

   `ASSERT_NEXT(a_busy_after_beat, clock, reset, req_valid && req_ready, !req_ready)
   `ASSERT_IMPLIES(a_no_overwrite, clock, reset, cmd.publish, !status.rsp_busy)
   `ASSERT_NEXT(a_publish_shows, clock, reset, cmd.publish, rsp_valid)
   `ASSERT_IMPLIES(a_one_step, clock, reset, 1'b1, $onehot0(strobes))

endmodule

@@ hw/rtl/lbss_ctrl.sv @@
// ---------------------------------------------------------------------------
// lightmap sampler controller
// sequences accumulation, interpolation and gain one channel at a time
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbss_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  lbss_pkg::status_type status,
   output lbss_pkg::cmd_type    cmd
);

   lbss_pkg::state_type state_ff, state_in;
   logic [1:0]          chan_ff, chan_in;
   logic                chan_end;

   assign chan_end  = (chan_ff == lbss_pkg::CH_BLUE);
   assign req_ready = (state_ff == lbss_pkg::S_IDLE);

   always_comb begin
      state_in      = state_ff;
      chan_in       = chan_ff;
      cmd           = '0;
      cmd.chan      = chan_ff;
      case (state_ff)
         lbss_pkg::S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               chan_in  = lbss_pkg::CH_RED;
               state_in = lbss_pkg::S_ACCUM;
            end
         end
         lbss_pkg::S_ACCUM: begin
            cmd.accum = 1'b1;
            if (chan_end) begin
               chan_in  = lbss_pkg::CH_RED;
               state_in = status.last_style ? lbss_pkg::S_ROW : lbss_pkg::S_IDLE;
            end else begin
               chan_in = chan_ff + 2'd1;
            end
         end
         lbss_pkg::S_ROW: begin
            cmd.lerp_row = 1'b1;
            state_in     = lbss_pkg::S_COL;
         end
         lbss_pkg::S_COL: begin
            cmd.lerp_col = 1'b1;
            state_in     = lbss_pkg::S_GAIN;
         end
         lbss_pkg::S_GAIN: begin
            cmd.gain_step = 1'b1;
            if (chan_end) begin
               chan_in  = lbss_pkg::CH_RED;
               state_in = lbss_pkg::S_PUBLISH;
            end else begin
               chan_in  = chan_ff + 2'd1;
               state_in = lbss_pkg::S_ROW;
            end
         end
         lbss_pkg::S_PUBLISH: begin
            if (!status.rsp_busy) begin
               cmd.publish = 1'b1;
               state_in    = lbss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = lbss_pkg::S_IDLE;
            chan_in  = lbss_pkg::CH_RED;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lbss_pkg::S_IDLE;
         chan_ff  <= lbss_pkg::CH_RED;
      end else begin
         state_ff <= state_in;
         chan_ff  <= chan_in;
      end
   end

endmodule

@@ hw/rtl/lbss_datapath.sv @@
// ---------------------------------------------------------------------------
// lightmap sampler datapath
// style accumulators, shared lerp and gain units, result register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lbss_datapath #(
   parameter int MAX_STYLES = 4
) (
   input  logic                   clock,
   input  logic                   reset,
   input  lbss_pkg::cmd_type      cmd,
   output lbss_pkg::status_type   status,
   input  lbss_pkg::req_type      req_data,
   input  logic                   csr_valid,
   input  logic [15:0]            csr_data,
   input  logic                   rsp_ready,
   output logic                   rsp_valid,
   output lbss_pkg::rsp_type      rsp_data
);

   localparam int CountWidth = $clog2(MAX_STYLES + 1);
   localparam int SW         = lbss_pkg::SumWidth;
   localparam int OW         = lbss_pkg::OutWidth;
   localparam int GW         = lbss_pkg::GainWidth;

   function automatic logic [SW-1:0] lerp16(input logic [SW-1:0] a,
                                            input logic [SW-1:0] b,
                                            input logic [3:0]    f);
      logic signed [SW:0]   d;
      logic signed [SW+5:0] p;
      logic signed [SW+1:0] r;
      d = $signed({1'b0, b}) - $signed({1'b0, a});
      p = (SW + 6)'(d) * (SW + 6)'($signed({1'b0, f}));
      r = (SW + 2)'(p >>> 4) + $signed({2'b00, a});
      return r[SW-1:0];
   endfunction

   lbss_pkg::req_type req_ff;
   logic              room_ff;
   logic [CountWidth-1:0] count_ff, count_in;
   logic [GW-1:0]     gain_ff;

   logic [3:0][SW-1:0] acc_ff [3];
   logic [3:0][SW-1:0] acc_in [3];
   logic [3:0][SW-1:0] row;
   logic [3:0][SW-1:0] row_new;

   logic [3:0][23:0] texel;
   logic [3:0][7:0]  texel_byte;
   logic [15:0]      scale;
   logic [23:0]      prod   [4];
   logic [SW:0]      sum    [4];

   logic [SW-1:0] top_ff, bot_ff, v_ff;
   logic [SW+GW-1:0] gain_prod;
   logic [SW+GW-9:0] gain_shift;
   logic [OW-1:0]    gain_sat;
   logic [OW-1:0]    stage_red_ff, stage_green_ff, stage_blue_ff;

   logic              rsp_valid_ff, rsp_valid_in;
   lbss_pkg::rsp_type rsp_ff;

   assign texel = {req_ff.texel_bottom_right, req_ff.texel_bottom_left,
                   req_ff.texel_top_right, req_ff.texel_top_left};

   // channel select for the accumulate and row lerp steps
   always_comb begin
      row   = acc_ff[0];
      scale = req_ff.style_scale_red;
      for (int c = 0; c < 4; c++) texel_byte[c] = texel[c][7:0];
      case (cmd.chan)
         lbss_pkg::CH_RED: begin
            row   = acc_ff[0];
            scale = req_ff.style_scale_red;
         end
         lbss_pkg::CH_GREEN: begin
            row   = acc_ff[1];
            scale = req_ff.style_scale_green;
            for (int c = 0; c < 4; c++) texel_byte[c] = texel[c][15:8];
         end
         lbss_pkg::CH_BLUE: begin
            row   = acc_ff[2];
            scale = req_ff.style_scale_blue;
            for (int c = 0; c < 4; c++) texel_byte[c] = texel[c][23:16];
         end
         default: begin
            row   = acc_ff[0];
            scale = req_ff.style_scale_red;
         end
      endcase
   end

   // four corner lanes, saturating add
   always_comb begin
      for (int c = 0; c < 4; c++) begin
         prod[c]    = {16'h0000, texel_byte[c]} * {8'h00, scale};
         sum[c]     = {1'b0, row[c]} + {3'b000, prod[c][23:8]};
         row_new[c] = sum[c][SW] ? lbss_pkg::SUM_MAX : sum[c][SW-1:0];
      end
   end

   always_comb begin
      acc_in = acc_ff;
      if (cmd.publish) begin
         for (int k = 0; k < 3; k++) acc_in[k] = '0;
      end else if (cmd.accum && room_ff) begin
         case (cmd.chan)
            lbss_pkg::CH_RED:   acc_in[0] = row_new;
            lbss_pkg::CH_GREEN: acc_in[1] = row_new;
            lbss_pkg::CH_BLUE:  acc_in[2] = row_new;
            default:            acc_in = acc_ff;
         endcase
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.publish) begin
         count_in = '0;
      end else if (cmd.load && (count_ff < CountWidth'(MAX_STYLES))) begin
         count_in = count_ff + CountWidth'(1);
      end
   end

   assign gain_prod  = {{GW{1'b0}}, v_ff} * {{SW{1'b0}}, gain_ff};
   assign gain_shift = gain_prod[SW+GW-1:8];
   assign gain_sat   = (|gain_shift[SW+GW-9:OW]) ? lbss_pkg::OUT_MAX : gain_shift[OW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 3; k++) acc_ff[k] <= '0;
         count_ff <= '0;
         room_ff  <= 1'b0;
         gain_ff  <= lbss_pkg::GAIN_RESET;
      end else begin
         acc_ff   <= acc_in;
         count_ff <= count_in;
         if (cmd.load) room_ff <= (count_ff < CountWidth'(MAX_STYLES));
         if (csr_valid) gain_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) req_ff <= req_data;
      if (cmd.lerp_row) begin
         top_ff <= lerp16(row[0], row[1], req_ff.frac_s);
         bot_ff <= lerp16(row[2], row[3], req_ff.frac_s);
      end
      if (cmd.lerp_col) v_ff <= lerp16(top_ff, bot_ff, req_ff.frac_t);
      if (cmd.gain_step) begin
         case (cmd.chan)
            lbss_pkg::CH_RED:   stage_red_ff   <= gain_sat;
            lbss_pkg::CH_GREEN: stage_green_ff <= gain_sat;
            lbss_pkg::CH_BLUE:  stage_blue_ff  <= gain_sat;
            default:            stage_red_ff   <= stage_red_ff;
         endcase
      end
      if (cmd.publish) begin
         rsp_ff.light_red   <= stage_red_ff;
         rsp_ff.light_green <= stage_green_ff;
         rsp_ff.light_blue  <= stage_blue_ff;
      end
   end

   assign rsp_valid_in = cmd.publish | (rsp_valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_data          = rsp_ff;
   assign status.last_style = req_ff.last_style;
   assign status.rsp_busy   = rsp_valid_ff & ~rsp_ready;

endmodule

@@ bench/lightmap_sample_checker.sv @@
// ---------------------------------------------------------------------------
// lightmap sampler checker
// watches the map, light and gain channels, predicts every light beat from
// the accepted style maps and compares it field by field in order
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module lightmap_sample_checker
   import lbss_pkg::*;
#(
   parameter int MAX_STYLES = 4
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  req_type              req_data,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  rsp_type              rsp_data,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [GainWidth-1:0] csr_data,
   output int                   fail_count,
   output int                   pending
);

   logic [SumWidth-1:0]  corner_sums [12];
   int                   styles_taken;
   logic [GainWidth-1:0] light_gain;
   rsp_type              expected_light [$];

   task automatic clear_corner_sums();
      for (int i = 0; i < 12; i++) begin
         corner_sums[i] = '0;
      end
      styles_taken = 0;
   endtask

   task automatic accumulate_map(input req_type m);
      logic [23:0] texel [4];
      logic [15:0] scale [3];
      longint      tex_val;
      longint      scale_val;
      longint      total;
      texel[0] = m.texel_top_left;
      texel[1] = m.texel_top_right;
      texel[2] = m.texel_bottom_left;
      texel[3] = m.texel_bottom_right;
      scale[0] = m.style_scale_red;
      scale[1] = m.style_scale_green;
      scale[2] = m.style_scale_blue;
      // maps past the style limit add nothing
      if (styles_taken < MAX_STYLES) begin
         for (int c = 0; c < 4; c++) begin
            for (int ch = 0; ch < 3; ch++) begin
               tex_val   = longint'(texel[c][8*ch +: 8]);
               scale_val = longint'(scale[ch]);
               total     = longint'(corner_sums[c*3 + ch]);
               total     = total + ((tex_val * scale_val) >>> 8);
               if (total > longint'(SUM_MAX)) begin
                  total = longint'(SUM_MAX);
               end
               corner_sums[c*3 + ch] = total[SumWidth-1:0];
            end
         end
         styles_taken++;
      end
   endtask

   function automatic longint blend_sixteenths(longint a, longint b, logic [3:0] f);
      longint fr;
      fr = longint'(f);
      return (((b - a) * fr) >>> 4) + a;
   endfunction

   function automatic rsp_type resolve_light();
      rsp_type             light;
      logic [OutWidth-1:0] chan [3];
      longint              top_row;
      longint              bottom_row;
      longint              level;
      longint              gained;
      longint              gain_val;
      gain_val = longint'(light_gain);
      for (int ch = 0; ch < 3; ch++) begin
         top_row    = blend_sixteenths(longint'(corner_sums[ch]),
                                       longint'(corner_sums[3 + ch]), req_data.frac_s);
         bottom_row = blend_sixteenths(longint'(corner_sums[6 + ch]),
                                       longint'(corner_sums[9 + ch]), req_data.frac_s);
         level      = blend_sixteenths(top_row, bottom_row, req_data.frac_t);
         if (level < 0) begin
            level = 0;
         end
         gained = (level * gain_val) >>> 8;
         if (gained > longint'(OUT_MAX)) begin
            gained = longint'(OUT_MAX);
         end
         chan[ch] = gained[OutWidth-1:0];
      end
      light.light_red   = chan[0];
      light.light_green = chan[1];
      light.light_blue  = chan[2];
      return light;
   endfunction

   task automatic check_light(input rsp_type got);
      rsp_type             want;
      logic [OutWidth-1:0] want_c [3];
      logic [OutWidth-1:0] got_c [3];
      string               chan_name [3];
      chan_name = '{"red", "green", "blue"};
      if (expected_light.size() == 0) begin
         $display("%0t: light beat with nothing expected, r=%0d g=%0d b=%0d", $time,
                  got.light_red, got.light_green, got.light_blue);
         fail_count++;
      end else begin
         want   = expected_light.pop_front();
         want_c = '{want.light_red, want.light_green, want.light_blue};
         got_c  = '{got.light_red, got.light_green, got.light_blue};
         for (int ch = 0; ch < 3; ch++) begin
            if (want_c[ch] != got_c[ch]) begin
               $display("%0t: light_%s expected %0d got %0d", $time, chan_name[ch],
                        want_c[ch], got_c[ch]);
               fail_count++;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_corner_sums();
         light_gain = GAIN_RESET;
         expected_light.delete();
         fail_count = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            light_gain = csr_data;
         end
         if (rsp_valid && rsp_ready) begin
            check_light(rsp_data);
         end
         if (req_valid && req_ready) begin
            accumulate_map(req_data);
            if (req_data.last_style) begin
               expected_light.push_back(resolve_light());
               clear_corner_sums();
            end
         end
      end
      pending = expected_light.size();
   end

endmodule

@@ bench/tb_lightmap_bilinear_style_sampler.sv @@
// ---------------------------------------------------------------------------
// lightmap bilinear style sampler testbench
// directed corner cases then randomised sample points over several gains,
// with random idling on both channels and one long light back-pressure spell
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_lightmap_bilinear_style_sampler;
   import lbss_pkg::*;

   localparam int MaxStyles  = 4;
   localparam int CycleLimit = 500000;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   req_type              req_data;
   logic                 rsp_valid;
   logic                 rsp_ready;
   rsp_type              rsp_data;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [GainWidth-1:0] csr_data;

   int fail_count;
   int pending;
   int cycle_count;
   int maps_sent;
   int rsp_hold_cycles;
   bit req_steady;
   bit rsp_steady;

   lightmap_bilinear_style_sampler #(
      .MAX_STYLES(MaxStyles)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_data (csr_data)
   );

   lightmap_sample_checker #(
      .MAX_STYLES(MaxStyles)
   ) light_check (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .fail_count(fail_count),
      .pending   (pending)
   );

   initial begin
      clock = 1'b0;
   end

   always #5 clock = ~clock;

   initial begin
      cycle_count = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   initial begin
      wait (cycle_count == CycleLimit);
      $display("lightmap_bilinear_style_sampler test failed");
      $finish;
   end

   function automatic req_type make_map(logic [23:0] tl, logic [23:0] tr, logic [23:0] bl,
                                        logic [23:0] br, logic [15:0] sr, logic [15:0] sg,
                                        logic [15:0] sb, logic [3:0] fs, logic [3:0] ft,
                                        logic last);
      req_type m;
      m.texel_top_left     = tl;
      m.texel_top_right    = tr;
      m.texel_bottom_left  = bl;
      m.texel_bottom_right = br;
      m.style_scale_red    = sr;
      m.style_scale_green  = sg;
      m.style_scale_blue   = sb;
      m.frac_s             = fs;
      m.frac_t             = ft;
      m.last_style         = last;
      return m;
   endfunction

   function automatic req_type random_map(logic last);
      logic [23:0] texel [4];
      logic [15:0] scale [3];
      for (int c = 0; c < 4; c++) begin
         case ($urandom_range(0, 7))
            0:       texel[c] = '0;
            1:       texel[c] = '1;
            default: texel[c] = 24'($urandom);
         endcase
      end
      for (int ch = 0; ch < 3; ch++) begin
         case ($urandom_range(0, 7))
            0:       scale[ch] = '0;
            1:       scale[ch] = '1;
            default: scale[ch] = 16'($urandom);
         endcase
      end
      return make_map(texel[0], texel[1], texel[2], texel[3], scale[0], scale[1], scale[2],
                      4'($urandom), 4'($urandom), last);
   endfunction

   // entered and left just after a falling edge
   task automatic send_map(input req_type m);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= m;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      maps_sent++;
   endtask

   task automatic send_point();
      int maps;
      if ($urandom_range(0, 9) == 0) begin
         send_map(random_map(1'($urandom_range(0, 1))));
      end else begin
         maps = ($urandom_range(0, 4) == 0) ? $urandom_range(5, 6) : $urandom_range(1, 4);
         for (int i = 0; i < maps; i++) begin
            send_map(random_map(i == maps - 1));
         end
      end
   endtask

   task automatic settle_block();
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic program_gain(input logic [GainWidth-1:0] gain);
      csr_valid <= 1'b1;
      csr_data  <= gain;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_phase(input logic [GainWidth-1:0] gain, input int count,
                            input bit rq_steady, input bit rs_steady);
      int target;
      settle_block();
      program_gain(gain);
      req_steady = rq_steady;
      rsp_steady = rs_steady;
      target = maps_sent + count;
      while (maps_sent < target) send_point();
   endtask

   // light side: random stall per beat, or a long hold-off when asked
   initial begin
      int stall;
      rsp_ready = 1'b0;
      wait (!reset);
      @(negedge clock);
      forever begin
         if (rsp_hold_cycles > 0) begin
            stall = rsp_hold_cycles;
            rsp_hold_cycles = 0;
         end else begin
            stall = rsp_steady ? 0 : $urandom_range(0, 11);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data        = '0;
      csr_valid       = 1'b0;
      csr_data        = '0;
      maps_sent       = 0;
      rsp_hold_cycles = 0;
      req_steady      = 1'b0;
      rsp_steady      = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset gain
      send_map(make_map('0, '0, '0, '0, '0, '0, '0, 4'd0, 4'd0, 1'b1));
      send_map(make_map('1, '1, '1, '1, '1, '1, '1, 4'd15, 4'd15, 1'b1));
      // more styles than the block sums
      for (int i = 0; i < 6; i++) begin
         send_map(make_map('1, '1, '1, '1, '1, '1, '1, 4'd5, 4'd10, i == 5));
      end
      // top row falling, bottom row rising
      send_map(make_map(24'hFFFFFF, 24'h000000, 24'h000000, 24'hFFFFFF,
                        16'h0100, 16'h0100, 16'h0100, 4'd7, 4'd9, 1'b1));
      send_map(make_map(24'h0000FF, 24'h00FF00, 24'hFF0000, 24'h808080,
                        16'h1234, 16'h0100, 16'hABCD, 4'd3, 4'd12, 1'b1));
      send_map(make_map(24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F, 24'h7F7F7F,
                        16'h0180, 16'h0180, 16'h0180, 4'd0, 4'd0, 1'b0));
      // product floors to zero
      send_map(make_map(24'h010101, 24'h010101, 24'h010101, 24'h010101,
                        16'h0001, 16'h0001, 16'h0001, 4'd15, 4'd0, 1'b1));
      send_map(make_map(24'h000000, 24'h000000, 24'h000000, 24'hFFFFFF,
                        16'h0100, 16'h0200, 16'h0080, 4'd15, 4'd15, 1'b1));

      // output saturation at the top gain, then the zero gain
      settle_block();
      program_gain('1);
      send_map(make_map('1, '1, '1, '1, '1, '1, '1, 4'd0, 4'd0, 1'b1));
      for (int i = 0; i < 4; i++) begin
         send_map(make_map('1, '1, '1, '1, '1, '1, '1, 4'd8, 4'd8, i == 3));
      end
      settle_block();
      program_gain('0);
      send_map(make_map('1, '1, '1, '1, '1, '1, '1, 4'd15, 4'd15, 1'b1));

      run_phase(GAIN_RESET, 150, 1'b0, 1'b0);
      run_phase(16'hFFFF, 150, 1'b1, 1'b1);
      run_phase(16'h0000, 120, 1'b0, 1'b1);
      run_phase(16'h0001, 120, 1'b1, 1'b0);
      run_phase(16'($urandom), 150, 1'b0, 1'b0);

      // light side held off while maps keep coming
      settle_block();
      program_gain(16'h0200);
      req_steady      = 1'b1;
      rsp_steady      = 1'b0;
      rsp_hold_cycles = 300;
      repeat (60) send_point();

      run_phase(16'h0080, 150, 1'b0, 1'b0);
      run_phase(16'($urandom), 150, 1'b1, 1'b0);

      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (30) @(negedge clock);
      if (fail_count == 0) begin
         $display("lightmap_bilinear_style_sampler test passed");
      end else begin
         $display("lightmap_bilinear_style_sampler test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+hw/rtl
hw/rtl/lbss_pkg.sv
hw/rtl/lbss_ctrl.sv
hw/rtl/lbss_datapath.sv
hw/rtl/lightmap_bilinear_style_sampler.sv
bench/lightmap_sample_checker.sv
bench/tb_lightmap_bilinear_style_sampler.sv
